FILE: sv/tecov_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and types for the triangle tile coverage unit.
// Depends on nothing; every other file refers to it by scoped names.
package tecov_pkg;

  // Tile geometry and vertex fixed-point format
  localparam int unsigned TILE_SIDE = 8;
  localparam int unsigned TILE_N    = TILE_SIDE * TILE_SIDE;
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned UNIT      = 1 << FRAC_BITS;

  // Port widths
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned TILE_W     = 12;
  localparam int unsigned COV_W      = 64;
  localparam int unsigned SS_W       = 2;
  localparam int unsigned SCR_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SS_MAX     = (1 << SS_W) - 1;

  // Sample index on the supersample grid
  localparam int unsigned SAMP_W = TILE_W + $clog2(TILE_SIDE);
  // Edge delta between two vertices
  localparam int unsigned D_W = COORD_W + 1;
  // Sample center minus scaled vertex, signed
  localparam int unsigned PC_W = SAMP_W + FRAC_BITS + 2;
  localparam int unsigned VS_W = COORD_W + SS_MAX + 1;
  localparam int unsigned P_W  = ((PC_W > VS_W) ? PC_W : VS_W) + 1;
  // Edge products and edge value
  localparam int unsigned PR_W = D_W + P_W;
  localparam int unsigned E_W  = PR_W + 1;
  // Bounding box, screen limit and sample compares, signed
  localparam int unsigned C_W = COORD_W + SS_MAX + 2;

  // Register reset values
  localparam logic [SS_W-1:0]  SS_RESET  = '0;
  localparam logic [SCR_W-1:0] SCR_RESET = SCR_W'(1024);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SS_SHIFT = 2'd0,
    CFG_SCREEN_W = 2'd1,
    CFG_SCREEN_H = 2'd2
  } tecov_cfg_e;

  // Per-stage advance strobes handed to the edge evaluators
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } tecov_adv_t;

endpackage

FILE: sv/tecov_edge.sv
`timescale 1ns / 1ps
// One edge function evaluated over every sample of a tile, four register stages.
// Depends on tecov_pkg for widths and the stage advance struct.
module tecov_edge (
  input  logic                                  clk_i,
  input  tecov_pkg::tecov_adv_t                 adv_i,
  input  logic signed [tecov_pkg::D_W-1:0]      dx_i,
  input  logic signed [tecov_pkg::D_W-1:0]      dy_i,
  input  logic signed [tecov_pkg::P_W-1:0]      qx_i,
  input  logic signed [tecov_pkg::P_W-1:0]      qy_i,
  output logic        [tecov_pkg::TILE_N-1:0]   ge_o,
  output logic        [tecov_pkg::TILE_N-1:0]   le_o
);

  localparam int unsigned T    = tecov_pkg::TILE_SIDE;
  localparam int unsigned N    = tecov_pkg::TILE_N;
  localparam int unsigned PR_W = tecov_pkg::PR_W;
  localparam int unsigned E_W  = tecov_pkg::E_W;
  localparam int unsigned STEP = tecov_pkg::FRAC_BITS + 1;

  // Stage 2: the two cross-product terms at the tile origin
  logic signed [PR_W-1:0]           mx_d, my_d, mx_q, my_q;
  logic signed [tecov_pkg::D_W-1:0] dx2_q, dy2_q;

  assign mx_d = PR_W'(dx_i) * PR_W'(qy_i);
  assign my_d = PR_W'(dy_i) * PR_W'(qx_i);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      mx_q  <= mx_d;
      my_q  <= my_d;
      dx2_q <= dx_i;
      dy2_q <= dy_i;
    end
  end

  // Stage 3: origin value plus per-row and per-column increments
  logic signed [E_W-1:0] e0_d, e0_q;
  logic signed [E_W-1:0] dxe, dye;
  logic signed [E_W-1:0] rowoff_d [T];
  logic signed [E_W-1:0] rowoff_q [T];
  logic signed [E_W-1:0] coloff_d [T];
  logic signed [E_W-1:0] coloff_q [T];

  assign e0_d = E_W'(mx_q) - E_W'(my_q);
  assign dxe  = E_W'(dx2_q);
  assign dye  = E_W'(dy2_q);

  for (genvar i = 0; i < T; i++) begin : g_off
    // one grid step moves the sample center by two half-sample units
    assign rowoff_d[i] = (dxe * E_W'(i)) <<< STEP;
    assign coloff_d[i] = -((dye * E_W'(i)) <<< STEP);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      e0_q     <= e0_d;
      rowoff_q <= rowoff_d;
      coloff_q <= coloff_d;
    end
  end

  // Stage 4: value at the first sample of each row
  logic signed [E_W-1:0] rowb_d [T];
  logic signed [E_W-1:0] rowb_q [T];
  logic signed [E_W-1:0] col4_q [T];

  for (genvar i = 0; i < T; i++) begin : g_rowb
    assign rowb_d[i] = e0_q + rowoff_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      rowb_q <= rowb_d;
      col4_q <= coloff_q;
    end
  end

  // Stage 5: value at each sample, keep only the sign tests
  logic [N-1:0] ge_d, le_d, ge_q, le_q;

  for (genvar r = 0; r < T; r++) begin : g_row
    for (genvar c = 0; c < T; c++) begin : g_col
      logic signed [E_W-1:0] smp;
      assign smp            = rowb_q[r] + col4_q[c];
      assign ge_d[r*T + c]  = ~smp[E_W-1];
      assign le_d[r*T + c]  = smp[E_W-1] | (smp == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      ge_q <= ge_d;
      le_q <= le_d;
    end
  end

  assign ge_o = ge_q;
  assign le_o = le_q;

endmodule

FILE: sv/triangle_edge_coverage_tile_unit.sv
`timescale 1ns / 1ps
// Top level of the triangle tile coverage unit: config registers, setup,
// bounding box and screen masks, pipeline control. Uses tecov_pkg, tecov_edge.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+------------------------------
//   in      | to block  | in_valid_i / in_stall_o | three vertices, tile col/row
//   out     | from block| out_valid_o/out_stall_i | coverage mask, any_covered
//   cfg     | to block  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One beat enters per clock while in_stall_o is low; a result is produced
// by the six register stages (setup, edge multiply, origin sum,
// row sum, sample sum and sign test, mask merge into the output register).
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output holds; each stage still fills while a later one is empty,
// so in_stall_o rises only when all six stages hold a beat.
module triangle_edge_coverage_tile_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration
  input  logic                                    cfg_we_i,
  input  logic [tecov_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tecov_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [tecov_pkg::COORD_W-1:0]    vert_ax_i,
  input  logic signed [tecov_pkg::COORD_W-1:0]    vert_ay_i,
  input  logic signed [tecov_pkg::COORD_W-1:0]    vert_bx_i,
  input  logic signed [tecov_pkg::COORD_W-1:0]    vert_by_i,
  input  logic signed [tecov_pkg::COORD_W-1:0]    vert_cx_i,
  input  logic signed [tecov_pkg::COORD_W-1:0]    vert_cy_i,
  input  logic [tecov_pkg::TILE_W-1:0]            tile_col_i,
  input  logic [tecov_pkg::TILE_W-1:0]            tile_row_i,
  // output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [tecov_pkg::COV_W-1:0]             coverage_o,
  output logic                                    any_covered_o
);

  localparam int unsigned T      = tecov_pkg::TILE_SIDE;
  localparam int unsigned N      = tecov_pkg::TILE_N;
  localparam int unsigned CW     = tecov_pkg::COORD_W;
  localparam int unsigned SAMP_W = tecov_pkg::SAMP_W;
  localparam int unsigned D_W    = tecov_pkg::D_W;
  localparam int unsigned P_W    = tecov_pkg::P_W;
  localparam int unsigned C_W    = tecov_pkg::C_W;

  // Configuration registers
  logic [tecov_pkg::SS_W-1:0]  ss_shift_q;
  logic [tecov_pkg::SCR_W-1:0] scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_shift_q <= tecov_pkg::SS_RESET;
      scr_w_q    <= tecov_pkg::SCR_RESET;
      scr_h_q    <= tecov_pkg::SCR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tecov_pkg::CFG_SS_SHIFT: ss_shift_q <= cfg_data_i[tecov_pkg::SS_W-1:0];
        tecov_pkg::CFG_SCREEN_W: scr_w_q    <= cfg_data_i[tecov_pkg::SCR_W-1:0];
        tecov_pkg::CFG_SCREEN_H: scr_h_q    <= cfg_data_i[tecov_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or the next one loads
  logic [6:1]            stage_v_q;
  logic [6:1]            en;
  tecov_pkg::tecov_adv_t adv;

  assign en[6] = ~stage_v_q[6] | ~out_stall_i;
  assign en[5] = ~stage_v_q[5] | en[6];
  assign en[4] = ~stage_v_q[4] | en[5];
  assign en[3] = ~stage_v_q[3] | en[4];
  assign en[2] = ~stage_v_q[2] | en[3];
  assign en[1] = ~stage_v_q[1] | en[2];

  assign adv.s2 = en[2];
  assign adv.s3 = en[3];
  assign adv.s4 = en[4];
  assign adv.s5 = en[5];

  assign in_stall_o  = ~en[1];
  assign out_valid_o = stage_v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= '0;
    end else begin
      if (en[1]) stage_v_q[1] <= in_valid_i;
      if (en[2]) stage_v_q[2] <= stage_v_q[1];
      if (en[3]) stage_v_q[3] <= stage_v_q[2];
      if (en[4]) stage_v_q[4] <= stage_v_q[3];
      if (en[5]) stage_v_q[5] <= stage_v_q[4];
      if (en[6]) stage_v_q[6] <= stage_v_q[5];
    end
  end

  // Stage 1: edge deltas, tile origin relative to each vertex, vertex extents
  logic signed [CW-1:0]     vx [3];
  logic signed [CW-1:0]     vy [3];
  logic [SAMP_W-1:0]        sx0_d, sy0_d, sx0_q, sy0_q;
  logic signed [P_W-1:0]    pcx, pcy;
  logic [2:0]               vshift;
  logic signed [D_W-1:0]    dx_d [3];
  logic signed [D_W-1:0]    dy_d [3];
  logic signed [P_W-1:0]    qx_d [3];
  logic signed [P_W-1:0]    qy_d [3];
  logic signed [D_W-1:0]    dx_q [3];
  logic signed [D_W-1:0]    dy_q [3];
  logic signed [P_W-1:0]    qx_q [3];
  logic signed [P_W-1:0]    qy_q [3];
  logic signed [CW-1:0]     minx_d, maxx_d, miny_d, maxy_d;
  logic signed [CW-1:0]     minx_q, maxx_q, miny_q, maxy_q;
  logic signed [CW-1:0]     mnx_ab, mxx_ab, mny_ab, mxy_ab;

  assign vx[0] = vert_ax_i;
  assign vx[1] = vert_bx_i;
  assign vx[2] = vert_cx_i;
  assign vy[0] = vert_ay_i;
  assign vy[1] = vert_by_i;
  assign vy[2] = vert_cy_i;

  assign sx0_d  = SAMP_W'(tile_col_i) * SAMP_W'(T);
  assign sy0_d  = SAMP_W'(tile_row_i) * SAMP_W'(T);
  // sample center of the tile origin, in half-sample units times 2^FRAC_BITS
  assign pcx    = signed'(P_W'({sx0_d, 1'b1}) << tecov_pkg::FRAC_BITS);
  assign pcy    = signed'(P_W'({sy0_d, 1'b1}) << tecov_pkg::FRAC_BITS);
  assign vshift = {1'b0, ss_shift_q} + 3'd1;

  for (genvar v = 0; v < 3; v++) begin : g_setup
    assign dx_d[v] = D_W'(vx[(v+1)%3]) - D_W'(vx[v]);
    assign dy_d[v] = D_W'(vy[(v+1)%3]) - D_W'(vy[v]);
    assign qx_d[v] = pcx - (P_W'(vx[v]) <<< vshift);
    assign qy_d[v] = pcy - (P_W'(vy[v]) <<< vshift);
  end

  assign mnx_ab = (vert_ax_i < vert_bx_i) ? vert_ax_i : vert_bx_i;
  assign mxx_ab = (vert_ax_i > vert_bx_i) ? vert_ax_i : vert_bx_i;
  assign mny_ab = (vert_ay_i < vert_by_i) ? vert_ay_i : vert_by_i;
  assign mxy_ab = (vert_ay_i > vert_by_i) ? vert_ay_i : vert_by_i;
  assign minx_d = (mnx_ab < vert_cx_i) ? mnx_ab : vert_cx_i;
  assign maxx_d = (mxx_ab > vert_cx_i) ? mxx_ab : vert_cx_i;
  assign miny_d = (mny_ab < vert_cy_i) ? mny_ab : vert_cy_i;
  assign maxy_d = (mxy_ab > vert_cy_i) ? mxy_ab : vert_cy_i;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      qx_q   <= qx_d;
      qy_q   <= qy_d;
      sx0_q  <= sx0_d;
      sy0_q  <= sy0_d;
      minx_q <= minx_d;
      maxx_q <= maxx_d;
      miny_q <= miny_d;
      maxy_q <= maxy_d;
    end
  end

  // Stage 2: bounding box on the grid, screen limits, row and column masks
  logic signed [C_W-1:0] lo_x, hi_x, lo_y, hi_y, sw, sh;
  logic [T-1:0]          colm_d, rowm_d;
  logic [T-1:0]          colm2_q, rowm2_q, colm3_q, rowm3_q;
  logic [T-1:0]          colm4_q, rowm4_q, colm5_q, rowm5_q;

  assign lo_x = (C_W'(minx_q) >>> tecov_pkg::FRAC_BITS) <<< ss_shift_q;
  assign lo_y = (C_W'(miny_q) >>> tecov_pkg::FRAC_BITS) <<< ss_shift_q;
  assign hi_x = ((C_W'(maxx_q) + signed'(C_W'(tecov_pkg::UNIT - 1)))
                 >>> tecov_pkg::FRAC_BITS) <<< ss_shift_q;
  assign hi_y = ((C_W'(maxy_q) + signed'(C_W'(tecov_pkg::UNIT - 1)))
                 >>> tecov_pkg::FRAC_BITS) <<< ss_shift_q;
  assign sw   = signed'(C_W'(scr_w_q) << ss_shift_q);
  assign sh   = signed'(C_W'(scr_h_q) << ss_shift_q);

  for (genvar i = 0; i < T; i++) begin : g_mask
    logic signed [C_W-1:0] sxc, syc;
    assign sxc       = signed'(C_W'(sx0_q) + C_W'(i));
    assign syc       = signed'(C_W'(sy0_q) + C_W'(i));
    assign colm_d[i] = (sxc >= lo_x) && (sxc < hi_x) && (sxc < sw);
    assign rowm_d[i] = (syc >= lo_y) && (syc < hi_y) && (syc < sh);
  end

  // Carry the masks alongside the edge pipeline
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      colm2_q <= colm_d;
      rowm2_q <= rowm_d;
    end
    if (en[3]) begin
      colm3_q <= colm2_q;
      rowm3_q <= rowm2_q;
    end
    if (en[4]) begin
      colm4_q <= colm3_q;
      rowm4_q <= rowm3_q;
    end
    if (en[5]) begin
      colm5_q <= colm4_q;
      rowm5_q <= rowm4_q;
    end
  end

  // Stages 2 to 5: one evaluator per edge
  logic [N-1:0] ge [3];
  logic [N-1:0] le [3];

  for (genvar v = 0; v < 3; v++) begin : g_edge
    tecov_edge u_edge (
      .clk_i (clk_i),
      .adv_i (adv),
      .dx_i  (dx_q[v]),
      .dy_i  (dy_q[v]),
      .qx_i  (qx_q[v]),
      .qy_i  (qy_q[v]),
      .ge_o  (ge[v]),
      .le_o  (le[v])
    );
  end

  // Stage 6: same sign on every edge of the triangle, inside box and screen
  logic [N-1:0]                  in_tri;
  logic [N-1:0]                  cov_d;
  logic [tecov_pkg::COV_W-1:0]   cov_full, cov_q;
  logic                          any_q;

  assign in_tri = (ge[0] & ge[1] & ge[2]) | (le[0] & le[1] & le[2]);

  for (genvar r = 0; r < T; r++) begin : g_cr
    for (genvar c = 0; c < T; c++) begin : g_cc
      assign cov_d[r*T + c] = in_tri[r*T + c] & rowm5_q[r] & colm5_q[c];
    end
  end

  assign cov_full = tecov_pkg::COV_W'(cov_d);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      cov_q <= cov_full;
      any_q <= |cov_d;
    end
  end

  assign coverage_o    = cov_q;
  assign any_covered_o = any_q;

  // Checks
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&stage_v_q) && out_stall_i))
    else $error("input stalled while a pipeline stage is empty");

  a_any_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (any_covered_o == (coverage_o != '0)))
    else $error("any_covered disagrees with coverage mask");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_v_q[5] && !stage_v_q[6]) |=> stage_v_q[6])
    else $error("beat in stage five did not move into an empty output stage");

endmodule

FILE: test/tb_triangle_edge_coverage_tile_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for triangle_edge_coverage_tile_unit: directed and random
// triangle/tile beats scored against an edge-function coverage predictor.
// Depends on tecov_pkg and the unit under test only.
module tb_triangle_edge_coverage_tile_unit;

  localparam int SIDE         = tecov_pkg::TILE_SIDE;
  localparam int FRAC         = tecov_pkg::FRAC_BITS;
  localparam int CW           = tecov_pkg::COORD_W;
  localparam int TW           = tecov_pkg::TILE_W;
  localparam int DW           = tecov_pkg::CFG_DATA_W;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 80;
  // Register index that decodes to nothing
  localparam logic [tecov_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [tecov_pkg::COORD_W-1:0] ax;
    logic [tecov_pkg::COORD_W-1:0] ay;
    logic [tecov_pkg::COORD_W-1:0] bx;
    logic [tecov_pkg::COORD_W-1:0] by;
    logic [tecov_pkg::COORD_W-1:0] cx;
    logic [tecov_pkg::COORD_W-1:0] cy;
    logic [tecov_pkg::TILE_W-1:0]  col;
    logic [tecov_pkg::TILE_W-1:0]  row;
  } tri_beat_t;

  // Scoreboard: own copy of the registers and a queue of predicted masks
  class coverage_scoreboard;
    bit [tecov_pkg::SS_W-1:0]  ss_shift = tecov_pkg::SS_RESET;
    bit [tecov_pkg::SCR_W-1:0] scr_w    = tecov_pkg::SCR_RESET;
    bit [tecov_pkg::SCR_W-1:0] scr_h    = tecov_pkg::SCR_RESET;
    bit [tecov_pkg::COV_W-1:0] expected_masks[$];
    int                        n_errors;

    function void set_reg(logic [tecov_pkg::CFG_IDX_W-1:0] idx,
                          logic [tecov_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tecov_pkg::CFG_SS_SHIFT: ss_shift = data[tecov_pkg::SS_W-1:0];
        tecov_pkg::CFG_SCREEN_W: scr_w = data[tecov_pkg::SCR_W-1:0];
        tecov_pkg::CFG_SCREEN_H: scr_h = data[tecov_pkg::SCR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint min3(longint v[3]);
      longint m;
      m = (v[0] < v[1]) ? v[0] : v[1];
      return (m < v[2]) ? m : v[2];
    endfunction

    function longint max3(longint v[3]);
      longint m;
      m = (v[0] > v[1]) ? v[0] : v[1];
      return (m > v[2]) ? m : v[2];
    endfunction

    // Evaluate the edge function of each triangle edge at every sample center of the tile
    function bit [tecov_pkg::COV_W-1:0] tile_mask(tri_beat_t t);
      longint vx[3], vy[3], ex[3], ey[3];
      longint mult, lo_x, hi_x, lo_y, hi_y, lim_x, lim_y;
      longint sx, sy, px, py, ed;
      bit [tecov_pkg::COV_W-1:0] mask;
      bit pos, neg;
      int nk;
      mask  = '0;
      vx[0] = $signed(t.ax);
      vy[0] = $signed(t.ay);
      vx[1] = $signed(t.bx);
      vy[1] = $signed(t.by);
      vx[2] = $signed(t.cx);
      vy[2] = $signed(t.cy);
      mult  = longint'(1) << ss_shift;
      // pixel bounding box: floor of the minimum, ceil of the maximum
      lo_x  = (min3(vx) >>> FRAC) * mult;
      hi_x  = (-((-max3(vx)) >>> FRAC)) * mult;
      lo_y  = (min3(vy) >>> FRAC) * mult;
      hi_y  = (-((-max3(vy)) >>> FRAC)) * mult;
      lim_x = longint'(scr_w) * mult;
      lim_y = longint'(scr_h) * mult;
      for (int k = 0; k < 3; k++) begin
        ex[k] = vx[k] * mult * 2;
        ey[k] = vy[k] * mult * 2;
      end
      for (int r = 0; r < SIDE; r++) begin
        sy = longint'(t.row) * SIDE + r;
        if (sy >= lim_y || sy < lo_y || sy >= hi_y) continue;
        for (int c = 0; c < SIDE; c++) begin
          sx = longint'(t.col) * SIDE + c;
          if (sx >= lim_x || sx < lo_x || sx >= hi_x) continue;
          px  = (2 * sx + 1) * (longint'(1) << FRAC);
          py  = (2 * sy + 1) * (longint'(1) << FRAC);
          pos = 1'b1;
          neg = 1'b1;
          for (int k = 0; k < 3; k++) begin
            nk = (k + 1) % 3;
            ed = (ex[nk] - ex[k]) * (py - ey[k]) - (ey[nk] - ey[k]) * (px - ex[k]);
            if (ed < 0) pos = 1'b0;
            if (ed > 0) neg = 1'b0;
          end
          // either winding, points on an edge included
          if (pos || neg) mask[r * SIDE + c] = 1'b1;
        end
      end
      return mask;
    endfunction

    function void note_triangle(tri_beat_t t);
      expected_masks.push_back(tile_mask(t));
    endfunction

    function void check_mask(logic [tecov_pkg::COV_W-1:0] cov, logic any);
      bit [tecov_pkg::COV_W-1:0] want;
      if (expected_masks.size() == 0) begin
        $error("coverage beat with no triangle outstanding: %h", cov);
        n_errors++;
        return;
      end
      want = expected_masks.pop_front();
      if (cov !== want) begin
        $error("coverage: expected %h, got %h", want, cov);
        n_errors++;
      end
      if (any !== (|want)) begin
        $error("any_covered: expected %0b, got %0b", |want, any);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [tecov_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tecov_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic [tecov_pkg::COV_W-1:0]      coverage_o;
  logic                             any_covered_o;
  tri_beat_t                        cur_tri;

  coverage_scoreboard sb;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_off_cycles = 0;
  int quiet_cycles    = 0;

  triangle_edge_coverage_tile_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .vert_ax_i    (cur_tri.ax),
    .vert_ay_i    (cur_tri.ay),
    .vert_bx_i    (cur_tri.bx),
    .vert_by_i    (cur_tri.by),
    .vert_cx_i    (cur_tri.cx),
    .vert_cy_i    (cur_tri.cy),
    .tile_col_i   (cur_tri.col),
    .tile_row_i   (cur_tri.row),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .coverage_o   (coverage_o),
    .any_covered_o(any_covered_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sample both channels mid-cycle; a beat seen here moves at the next edge
  always @(negedge clk_i) begin
    bit took_in, took_out;
    took_in  = in_valid_i && !in_stall_o;
    took_out = out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (took_in) sb.note_triangle(cur_tri);
      if (took_out) sb.check_mask(coverage_o, any_covered_o);
      quiet_cycles <= (took_in || took_out) ? 0 : quiet_cycles + 1;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin : receiver
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  function automatic tri_beat_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                       int col, int row);
    tri_beat_t t;
    t.ax  = CW'(ax);
    t.ay  = CW'(ay);
    t.bx  = CW'(bx);
    t.by  = CW'(by);
    t.cx  = CW'(cx);
    t.cy  = CW'(cy);
    t.col = TW'(col);
    t.row = TW'(row);
    return t;
  endfunction

  // Mostly triangles placed around a reachable tile; some raw noise
  function automatic tri_beat_t random_tri();
    tri_beat_t t;
    int v[6];
    int ss, col_max, row_max, cap, span, reach, ox, oy;
    if ($urandom_range(99) < 12) begin
      return mk_tri(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    end
    ss      = int'(sb.ss_shift);
    cap     = (256 << ss) - 1;
    col_max = ((int'(sb.scr_w) << ss) / SIDE) + 1;
    row_max = ((int'(sb.scr_h) << ss) / SIDE) + 1;
    if (col_max > cap) col_max = cap;
    if (row_max > cap) row_max = cap;
    t.col = TW'($urandom_range(col_max));
    t.row = TW'($urandom_range(row_max));
    // tile side in vertex units, then center the triangle on the tile
    span = (SIDE << FRAC) >> ss;
    ox   = int'(t.col) * span + span / 2;
    oy   = int'(t.row) * span + span / 2;
    case ($urandom_range(3))
      0: reach = span / 2;
      1: reach = span;
      2: reach = 4 * span;
      default: reach = 40 * span;
    endcase
    for (int k = 0; k < 6; k++) begin
      v[k] = ((k % 2) ? oy : ox) + int'($urandom_range(2 * reach)) - reach;
      if (v[k] > 32767) v[k] = 32767;
      if (v[k] < -32768) v[k] = -32768;
    end
    // snap to half pixels now and then so edges run through sample centers
    if ($urandom_range(3) == 0) begin
      for (int k = 0; k < 6; k++) v[k] = (v[k] >>> 3) <<< 3;
    end
    t.ax = CW'(v[0]);
    t.ay = CW'(v[1]);
    t.bx = CW'(v[2]);
    t.by = CW'(v[3]);
    t.cx = CW'(v[4]);
    t.cy = CW'(v[5]);
    return t;
  endfunction

  // Offer one beat, with an optional idle gap first; return once it is taken
  task automatic send_tri(input tri_beat_t t);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    cur_tri    <= t;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [tecov_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= DW'(value);
    sb.set_reg(idx, DW'(value));
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every predicted mask, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(int ss, int w, int h, int send_pct, int recv_pct, int n,
                           int hold);
    write_reg(tecov_pkg::CFG_SS_SHIFT, ss);
    write_reg(tecov_pkg::CFG_SCREEN_W, w);
    write_reg(tecov_pkg::CFG_SCREEN_H, h);
    cfg_we_i       <= 1'b0;
    send_idle_pct   = send_pct;
    recv_stall_pct  = recv_pct;
    hold_off_cycles = hold;
    repeat (n) send_tri(random_tri());
    settle();
  endtask

  initial begin : main_seq
    sb = new;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= tecov_pkg::CFG_SS_SHIFT;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    cur_tri    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats on reset register values: one sample per pixel, 1024x1024
    send_tri(mk_tri(16, 16, 112, 16, 16, 112, 0, 0));
    send_tri(mk_tri(16, 16, 16, 112, 112, 16, 0, 0));
    send_tri(mk_tri(-32768, -32768, 32767, -32768, 32767, 32767, 0, 0));
    send_tri(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
    send_tri(mk_tri(32767, 32767, 32767, 32767, 32767, 32767, 4095, 4095));
    // all vertices on one pixel corner, then on one pixel center
    send_tri(mk_tri(80, 80, 80, 80, 80, 80, 0, 0));
    send_tri(mk_tri(88, 88, 88, 88, 88, 88, 0, 0));
    // collinear: a diagonal and a horizontal line through sample centers
    send_tri(mk_tri(0, 0, 128, 128, 64, 64, 0, 0));
    send_tri(mk_tri(0, 40, 128, 40, 64, 40, 0, 0));
    // edges running exactly through sample centers
    send_tri(mk_tri(8, 8, 120, 8, 8, 120, 0, 0));
    // large triangle against the screen edges
    send_tri(mk_tri(-16, -16, 32767, -16, -16, 32767, 127, 0));
    send_tri(mk_tri(-16, -16, 32767, -16, -16, 32767, 128, 0));
    send_tri(mk_tri(-16, -16, 32767, -16, -16, 32767, 0, 127));
    send_tri(mk_tri(-16, -16, 32767, -16, -16, 32767, 0, 128));
    send_tri(mk_tri(-16, -16, 32767, -16, -16, 32767, 4095, 0));
    send_tri(mk_tri(-16, -16, 32767, -16, -16, 32767, 0, 4095));
    // partial coverage from negative coordinates, and a thin sliver
    send_tri(mk_tri(-40, 20, 70, -30, 30, 100, 0, 0));
    send_tri(mk_tri(3, 3, 125, 7, 5, 9, 0, 0));
    settle();

    // Random phases over several register settings and idling patterns
    run_phase(0, 1024, 1024, 0, 0, 100, 0);
    run_phase(tecov_pkg::SS_MAX, 4096, 4096, 0, 0, 250, HOLD_CYCLES);
    run_phase(1, 640, 480, 47, 0, 300, 0);
    run_phase(2, 1, 1, 0, 47, 200, 0);
    write_reg(CFG_NONE, 13'h1FFF);
    run_phase(0, 8191, 0, 9, 9, 100, 0);
    run_phase(tecov_pkg::SS_MAX, 37, 8191, 9, 9, 250, 0);
    run_phase(2, 300, 200, 0, 0, 300, 0);

    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
